/* hw/rtl/c2s_pkg.sv */
`timescale 1ns / 1ps
package c2s_pkg;

   // field widths
   localparam int COORD_W    = 32;
   localparam int ANGLE_FRAC = 16;
   localparam int RADIUS_W   = COORD_W + 1;
   localparam int LAT_W      = ANGLE_FRAC + 8;
   localparam int LON_W      = ANGLE_FRAC + 10;
   localparam int SIN_W      = 32;
   localparam int COS_LAT_W  = 31;
   localparam int TOP_W      = $clog2(COORD_W);

   // internal widths
   localparam int NORM_W     = 31;
   localparam int NORM_MSB   = 30;
   localparam int SQ_W       = 64;
   localparam int ROOT_W     = 32;
   localparam int Q_W        = 31;
   localparam int XY_W       = 60;
   localparam int Z_W        = 64;
   localparam int ZC_W       = 61;
   localparam int K_W        = 38;
   localparam int OPD_SHIFT  = 26;
   localparam int DEG_SHIFT  = 92 - ANGLE_FRAC;
   localparam int SUM_W      = 100;

   // stage counts
   localparam int CORDIC_STEPS = 40;
   localparam int FRONT_LAT    = 5;
   localparam int SQRT_LAT     = ROOT_W;
   localparam int DIV_LAT      = Q_W;
   localparam int ANGLE_LAT    = CORDIC_STEPS + 3;
   localparam int PIPE_LAT     = FRONT_LAT + SQRT_LAT + DIV_LAT + ANGLE_LAT + 1;

   // constants
   localparam logic [Z_W-1:0] PI_4_Q60    = 64'h0C90FDAA22168C23;
   localparam logic [Z_W-1:0] QUARTER_Q60 = PI_4_Q60 << 1;
   localparam logic [K_W-1:0] RAD2DEG_Q32 = 38'd246083499208;
   localparam logic signed [LON_W-1:0] HALF_TURN = LON_W'(180 * (2 ** ANGLE_FRAC));

   typedef logic [CORDIC_STEPS-1:0][Z_W-1:0] angle_tab_type;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic neg_z;
      logic origin;
      logic polar;
   } side_type;

   // index of the highest set bit
   function automatic logic [TOP_W-1:0] msb_index(input logic [COORD_W-1:0] v);
      logic [TOP_W-1:0] top;
      top = '0;
      for (int b = 0; b < COORD_W; b++) begin
         if (v[b]) top = TOP_W'(b);
      end
      return top;
   endfunction

   // atan(2^-i) in q60, truncated arctangent series, long division by shift and subtract
   function automatic angle_tab_type build_angle_tab();
      angle_tab_type    tab;
      logic signed [Z_W-1:0] acc;
      logic [Z_W-1:0]   quo;
      logic [Z_W-1:0]   rem;
      logic [Z_W-1:0]   dv;
      int               e;
      tab = '0;
      tab[0] = PI_4_Q60;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
         acc = '0;
         for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
            e   = i * (2 * k + 1);
            dv  = Z_W'(2 * k + 1);
            quo = '0;
            rem = '0;
            for (int b = 60 - e; b >= 0; b--) begin
               rem = (rem << 1) | ((b == 60 - e) ? Z_W'(1) : Z_W'(0));
               if (rem >= dv) begin
                  rem    = rem - dv;
                  quo[b] = 1'b1;
               end
            end
            if (k % 2 == 1) acc = acc - $signed(quo);
            else acc = acc + $signed(quo);
         end
         tab[i] = acc;
      end
      return tab;
   endfunction

   localparam angle_tab_type ANGLE_TAB = build_angle_tab();

endpackage

/* hw/rtl/c2s_delay.sv */
`timescale 1ns / 1ps
module c2s_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // balancing shift line
   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

/* hw/rtl/c2s_isqrt.sv */
`timescale 1ns / 1ps
module c2s_isqrt (
   input  logic                       clock,
   input  logic                       en,
   input  logic [c2s_pkg::SQ_W-1:0]   rad_in,
   output logic [c2s_pkg::ROOT_W-1:0] root_out
);
   import c2s_pkg::*;

   localparam int REM_W = ROOT_W + 2;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [SQ_W-1:0]   num_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   logic [SQ_W-1:0]   num_in  [ROOT_W];

   // one root bit per stage, two radicand bits brought down each time
   always_comb begin
      logic [REM_W-1:0]  rem_prev;
      logic [REM_W-1:0]  rem_try;
      logic [REM_W-1:0]  trial;
      logic [ROOT_W-1:0] root_prev;
      logic [SQ_W-1:0]   num_prev;
      for (int g = 0; g < ROOT_W; g++) begin
         if (g == 0) begin
            rem_prev  = '0;
            root_prev = '0;
            num_prev  = rad_in;
         end else begin
            rem_prev  = rem_ff[g-1];
            root_prev = root_ff[g-1];
            num_prev  = num_ff[g-1];
         end
         rem_try = {rem_prev[REM_W-3:0], num_prev[SQ_W-1 -: 2]};
         trial   = {root_prev, 2'b01};
         if (rem_try >= trial) begin
            rem_in[g]  = rem_try - trial;
            root_in[g] = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[g]  = rem_try;
            root_in[g] = {root_prev[ROOT_W-2:0], 1'b0};
         end
         num_in[g] = num_prev << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         num_ff  <= num_in;
      end
   end

   assign root_out = root_ff[ROOT_W-1];

endmodule

/* hw/rtl/c2s_div.sv */
`timescale 1ns / 1ps
module c2s_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [c2s_pkg::ROOT_W-1:0] num_in,
   input  logic [c2s_pkg::ROOT_W-1:0] den_in,
   output logic [c2s_pkg::Q_W-1:0]    quo_out
);
   import c2s_pkg::*;

   localparam int REM_W = ROOT_W + 1;

   logic [REM_W-1:0]  rem_ff [Q_W];
   logic [ROOT_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]    quo_ff [Q_W];
   logic [REM_W-1:0]  rem_in [Q_W];
   logic [ROOT_W-1:0] den_in_s [Q_W];
   logic [Q_W-1:0]    quo_in [Q_W];

   // restoring division, numerator scaled by 2^30, one quotient bit per stage
   always_comb begin
      logic [REM_W-1:0]  rem_prev;
      logic [REM_W-1:0]  diff;
      logic [ROOT_W-1:0] den_prev;
      logic [Q_W-1:0]    quo_prev;
      logic              ge;
      for (int g = 0; g < Q_W; g++) begin
         if (g == 0) begin
            rem_prev = {1'b0, num_in};
            den_prev = den_in;
            quo_prev = '0;
         end else begin
            rem_prev = rem_ff[g-1];
            den_prev = den_ff[g-1];
            quo_prev = quo_ff[g-1];
         end
         ge   = rem_prev >= {1'b0, den_prev};
         diff = ge ? rem_prev - {1'b0, den_prev} : rem_prev;
         rem_in[g]   = diff << 1;
         den_in_s[g] = den_prev;
         quo_in[g]   = {quo_prev[Q_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= den_in_s;
         quo_ff <= quo_in;
      end
   end

   assign quo_out = quo_ff[Q_W-1];

endmodule

/* hw/rtl/c2s_angle.sv */
`timescale 1ns / 1ps
module c2s_angle (
   input  logic                      clock,
   input  logic                      en,
   input  logic [c2s_pkg::Q_W-1:0]   sin_in,
   input  logic [c2s_pkg::Q_W-1:0]   cos_in,
   output logic [c2s_pkg::LAT_W-1:0] deg_out
);
   import c2s_pkg::*;

   logic signed [XY_W-1:0] a_ff [CORDIC_STEPS];
   logic signed [XY_W-1:0] b_ff [CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_ff [CORDIC_STEPS];
   logic signed [XY_W-1:0] a_in [CORDIC_STEPS];
   logic signed [XY_W-1:0] b_in [CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_in [CORDIC_STEPS];
   logic [ZC_W-1:0]        zc_ff;
   logic [ZC_W-1:0]        zc_in;
   logic [ROOT_W+K_W-1:0]  p0_ff;
   logic [ZC_W-ROOT_W+K_W-1:0] p1_ff;
   logic [SUM_W-1:0]       sum;
   logic [LAT_W-1:0]       deg_ff;
   logic signed [Z_W-1:0]  z_last;

   // vectoring rotations, one micro-rotation per stage
   always_comb begin
      logic signed [XY_W-1:0] a_prev;
      logic signed [XY_W-1:0] b_prev;
      logic signed [Z_W-1:0]  z_prev;
      logic signed [XY_W-1:0] da;
      logic signed [XY_W-1:0] db;
      for (int g = 0; g < CORDIC_STEPS; g++) begin
         if (g == 0) begin
            a_prev = $signed(XY_W'({cos_in, {OPD_SHIFT{1'b0}}}));
            b_prev = $signed(XY_W'({sin_in, {OPD_SHIFT{1'b0}}}));
            z_prev = '0;
         end else begin
            a_prev = a_ff[g-1];
            b_prev = b_ff[g-1];
            z_prev = z_ff[g-1];
         end
         da = b_prev >>> g;
         db = a_prev >>> g;
         if (!b_prev[XY_W-1]) begin
            a_in[g] = a_prev + da;
            b_in[g] = b_prev - db;
            z_in[g] = z_prev + $signed(ANGLE_TAB[g]);
         end else begin
            a_in[g] = a_prev - da;
            b_in[g] = b_prev + db;
            z_in[g] = z_prev - $signed(ANGLE_TAB[g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         b_ff <= b_in;
         z_ff <= z_in;
      end
   end

   // clamp to a quarter turn
   assign z_last = z_ff[CORDIC_STEPS-1];
   always_comb begin
      priority if (z_last[Z_W-1]) zc_in = '0;
      else if ($unsigned(z_last) > QUARTER_Q60) zc_in = QUARTER_Q60[ZC_W-1:0];
      else zc_in = z_last[ZC_W-1:0];
   end

   // radians to degrees: partial products, then sum with rounding
   assign sum = {p1_ff, {ROOT_W{1'b0}}} + SUM_W'(p0_ff) + (SUM_W'(1) << (DEG_SHIFT - 1));

   always_ff @(posedge clock) begin
      if (en) begin
         zc_ff  <= zc_in;
         p0_ff  <= (ROOT_W+K_W)'(zc_ff[ROOT_W-1:0]) * (ROOT_W+K_W)'(RAD2DEG_Q32);
         p1_ff  <= (ZC_W-ROOT_W+K_W)'(zc_ff[ZC_W-1:ROOT_W])
                   * (ZC_W-ROOT_W+K_W)'(RAD2DEG_Q32);
         deg_ff <= sum[DEG_SHIFT +: LAT_W];
      end
   end

   assign deg_out = deg_ff;

endmodule

/* hw/rtl/cartesian_to_spherical.sv */
`timescale 1ns / 1ps
// throughput: one point per cycle unless the output stalls, fully pipelined (4 square-root
// pipes of 32 stages, 4 divider pipes of 31 stages, 2 cordic pipes of 40 stages plus
// degree scaling)
// a stalled output holds the whole pipeline; nothing is lost or repeated
// reset: synchronous, active high, clears the valid bits only
module cartesian_to_spherical (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // coord_x, coord_y, coord_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [215:0] rsp_tdata,   // radius, latitude, longitude, sin_lat, cos_lat,
                                     // sin_lon, cos_lon, zero pad
   output logic [0:0]   rsp_tuser    // degenerate
);
   import c2s_pkg::*;

   logic adv;
   logic [PIPE_LAT-1:0] vld_ff;

   logic [COORD_W-1:0] cx, cy, cz;
   logic [COORD_W-1:0] mag_x_ff, mag_y_ff, mag_z_ff;
   side_type           side_ff, side_in, side_end;
   logic [COORD_W-1:0] mag2_x_ff, mag2_y_ff, mag2_z_ff;
   logic [TOP_W-1:0]   top3_ff, top2_ff;
   logic [COORD_W-1:0] mag3_x_ff, mag3_y_ff, mag3_z_ff;
   logic [NORM_W-1:0]  nx_ff, ny_ff, nz_ff, hx_ff, hy_ff;
   logic [SQ_W-1:0]    sq_x_ff, sq_y_ff, sq_z_ff;
   logic [NORM_W*2-1:0] nsq_x_ff, nsq_y_ff, nsq_z_ff, hsq_x_ff, hsq_y_ff;
   logic [SQ_W-1:0]    rsum_ff, lsum_ff, hsum_ff, gsum_ff;

   logic [ROOT_W-1:0]  r_rad, r_lat, h_lat, g_lon, radius_d;
   logic [NORM_W-1:0]  nz_d, hx_d, hy_d;
   logic [Q_W-1:0]     sl_q, cl_q, s_q, c_q, sl_d, cl_d, s_d, c_d;
   logic [LAT_W-1:0]   lat_mag, lon_mag;

   logic [RADIUS_W-1:0]        radius_ff;
   logic signed [LAT_W-1:0]    lat_ff;
   logic signed [LON_W-1:0]    lon_ff;
   logic signed [SIN_W-1:0]    sin_lat_ff, sin_lon_ff, cos_lon_ff;
   logic [COS_LAT_W-1:0]       cos_lat_ff;
   logic                       degen_ff;

   logic signed [LAT_W-1:0]    lat_s;
   logic signed [LON_W-1:0]    lon_a, lon_s;
   logic                       cos_pos;

   // global advance: the output register is free or being drained
   assign adv        = !vld_ff[PIPE_LAT-1] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_tvalid};
      end
   end

   // stage 1: magnitudes and signs
   assign cx = req_tdata[COORD_W-1:0];
   assign cy = req_tdata[2*COORD_W-1:COORD_W];
   assign cz = req_tdata[3*COORD_W-1:2*COORD_W];

   always_comb begin
      side_in.neg_x  = cx[COORD_W-1];
      side_in.neg_y  = cy[COORD_W-1];
      side_in.neg_z  = cz[COORD_W-1];
      side_in.origin = (cx == '0) && (cy == '0) && (cz == '0);
      side_in.polar  = (cx == '0) && (cy == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_x_ff <= cx[COORD_W-1] ? -cx : cx;
         mag_y_ff <= cy[COORD_W-1] ? -cy : cy;
         mag_z_ff <= cz[COORD_W-1] ? -cz : cz;
         side_ff  <= side_in;
      end
   end

   // stage 2: leading bit of the largest magnitude
   always_ff @(posedge clock) begin
      if (adv) begin
         top3_ff   <= msb_index(mag_x_ff | mag_y_ff | mag_z_ff);
         top2_ff   <= msb_index(mag_x_ff | mag_y_ff);
         mag2_x_ff <= mag_x_ff;
         mag2_y_ff <= mag_y_ff;
         mag2_z_ff <= mag_z_ff;
      end
   end

   // stage 3: normalise so the largest term sits at bit 30
   function automatic logic [NORM_W-1:0] norm(input logic [COORD_W-1:0] m,
                                              input logic [TOP_W-1:0] top);
      logic [COORD_W-1:0] t;
      if (top < TOP_W'(NORM_MSB)) t = m << (TOP_W'(NORM_MSB) - top);
      else t = m >> (top - TOP_W'(NORM_MSB));
      return t[NORM_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff     <= norm(mag2_x_ff, top3_ff);
         ny_ff     <= norm(mag2_y_ff, top3_ff);
         nz_ff     <= norm(mag2_z_ff, top3_ff);
         hx_ff     <= norm(mag2_x_ff, top2_ff);
         hy_ff     <= norm(mag2_y_ff, top2_ff);
         mag3_x_ff <= mag2_x_ff;
         mag3_y_ff <= mag2_y_ff;
         mag3_z_ff <= mag2_z_ff;
      end
   end

   // stage 4: squares
   always_ff @(posedge clock) begin
      if (adv) begin
         sq_x_ff  <= SQ_W'(mag3_x_ff) * SQ_W'(mag3_x_ff);
         sq_y_ff  <= SQ_W'(mag3_y_ff) * SQ_W'(mag3_y_ff);
         sq_z_ff  <= SQ_W'(mag3_z_ff) * SQ_W'(mag3_z_ff);
         nsq_x_ff <= (2*NORM_W)'(nx_ff) * (2*NORM_W)'(nx_ff);
         nsq_y_ff <= (2*NORM_W)'(ny_ff) * (2*NORM_W)'(ny_ff);
         nsq_z_ff <= (2*NORM_W)'(nz_ff) * (2*NORM_W)'(nz_ff);
         hsq_x_ff <= (2*NORM_W)'(hx_ff) * (2*NORM_W)'(hx_ff);
         hsq_y_ff <= (2*NORM_W)'(hy_ff) * (2*NORM_W)'(hy_ff);
      end
   end

   // stage 5: sums of squares
   always_ff @(posedge clock) begin
      if (adv) begin
         rsum_ff <= sq_x_ff + sq_y_ff + sq_z_ff;
         lsum_ff <= SQ_W'(nsq_x_ff) + SQ_W'(nsq_y_ff) + SQ_W'(nsq_z_ff);
         hsum_ff <= SQ_W'(nsq_x_ff) + SQ_W'(nsq_y_ff);
         gsum_ff <= SQ_W'(hsq_x_ff) + SQ_W'(hsq_y_ff);
      end
   end

   // square roots
   c2s_isqrt u_sqrt_rad (.clock(clock), .en(adv), .rad_in(rsum_ff), .root_out(r_rad));
   c2s_isqrt u_sqrt_lat (.clock(clock), .en(adv), .rad_in(lsum_ff), .root_out(r_lat));
   c2s_isqrt u_sqrt_hor (.clock(clock), .en(adv), .rad_in(hsum_ff), .root_out(h_lat));
   c2s_isqrt u_sqrt_lon (.clock(clock), .en(adv), .rad_in(gsum_ff), .root_out(g_lon));

   c2s_delay #(.WIDTH(3*NORM_W), .DEPTH(SQRT_LAT + 2)) u_dly_num (
      .clock(clock), .en(adv),
      .din({nz_ff, hx_ff, hy_ff}), .dout({nz_d, hx_d, hy_d})
   );

   // quotients in q1.30
   c2s_div u_div_sl (.clock(clock), .en(adv), .num_in(ROOT_W'(nz_d)), .den_in(r_lat),
                     .quo_out(sl_q));
   c2s_div u_div_cl (.clock(clock), .en(adv), .num_in(h_lat), .den_in(r_lat),
                     .quo_out(cl_q));
   c2s_div u_div_s  (.clock(clock), .en(adv), .num_in(ROOT_W'(hx_d)), .den_in(g_lon),
                     .quo_out(s_q));
   c2s_div u_div_c  (.clock(clock), .en(adv), .num_in(ROOT_W'(hy_d)), .den_in(g_lon),
                     .quo_out(c_q));

   // angles
   c2s_angle u_ang_lat (.clock(clock), .en(adv), .sin_in(sl_q), .cos_in(cl_q),
                        .deg_out(lat_mag));
   c2s_angle u_ang_lon (.clock(clock), .en(adv), .sin_in(s_q), .cos_in(c_q),
                        .deg_out(lon_mag));

   // alignment of side values with the angle outputs
   c2s_delay #(.WIDTH(ROOT_W), .DEPTH(DIV_LAT + ANGLE_LAT)) u_dly_rad (
      .clock(clock), .en(adv), .din(r_rad), .dout(radius_d)
   );
   c2s_delay #(.WIDTH(4*Q_W), .DEPTH(ANGLE_LAT)) u_dly_trig (
      .clock(clock), .en(adv),
      .din({sl_q, cl_q, s_q, c_q}), .dout({sl_d, cl_d, s_d, c_d})
   );
   c2s_delay #(.WIDTH($bits(side_type)), .DEPTH(PIPE_LAT - 2)) u_dly_side (
      .clock(clock), .en(adv), .din(side_ff), .dout(side_end)
   );

   // signs and longitude quadrant
   assign lat_s   = side_end.neg_z ? -$signed(lat_mag) : $signed(lat_mag);
   assign lon_a   = side_end.neg_x ? -$signed(LON_W'(lon_mag)) : $signed(LON_W'(lon_mag));
   assign cos_pos = !side_end.neg_y && (c_d != '0);
   assign lon_s   = cos_pos ? lon_a : HALF_TURN - lon_a;

   // output register
   always_ff @(posedge clock) begin
      if (adv) begin
         if (side_end.origin) begin
            radius_ff  <= '0;
            lat_ff     <= '0;
            lon_ff     <= '0;
            sin_lat_ff <= '0;
            cos_lat_ff <= '0;
            sin_lon_ff <= '0;
            cos_lon_ff <= '0;
            degen_ff   <= 1'b1;
         end else begin
            radius_ff  <= RADIUS_W'(radius_d);
            cos_lat_ff <= COS_LAT_W'(cl_d);
            sin_lat_ff <= side_end.neg_z ? -$signed(SIN_W'(sl_d)) : $signed(SIN_W'(sl_d));
            if (side_end.polar) begin
               lat_ff     <= '0;
               lon_ff     <= '0;
               sin_lon_ff <= '0;
               cos_lon_ff <= '0;
               degen_ff   <= 1'b1;
            end else begin
               lat_ff     <= lat_s;
               lon_ff     <= lon_s;
               sin_lon_ff <= side_end.neg_x ? -$signed(SIN_W'(s_d)) : $signed(SIN_W'(s_d));
               cos_lon_ff <= side_end.neg_y ? -$signed(SIN_W'(c_d)) : $signed(SIN_W'(c_d));
               degen_ff   <= 1'b0;
            end
         end
      end
   end

   assign rsp_tvalid = vld_ff[PIPE_LAT-1];
   assign rsp_tdata  = {6'b0, cos_lon_ff, sin_lon_ff, cos_lat_ff, sin_lat_ff,
                        lon_ff, lat_ff, radius_ff};
   assign rsp_tuser  = degen_ff;

endmodule
